[hw/rtl/ssfa_pkg.sv]
package ssfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EPS_Q = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic [65:0] EPS_SQ = 66'(EPS_Q * EPS_Q);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_TARGET_X = 3'd1;
  localparam logic [2:0] REG_TARGET_Y = 3'd2;
  localparam logic [2:0] REG_TARGET_Z = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;

  typedef enum logic [1:0] {
    MODE_SEEK   = 2'd0,
    MODE_FLEE   = 2'd1,
    MODE_ARRIVE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_SCALE  = 2'd0,
    OP_DIRECT = 2'd1,
    OP_PASS   = 2'd2,
    OP_ZERO   = 2'd3
  } scl_op_t;

  typedef logic [2:0][32:0] vec33_t;
  typedef logic [2:0][31:0] vec32_t;

  typedef struct packed {
    logic        valid;
    vec32_t      pos;
    vec32_t      vel;
    logic [30:0] speed;
    logic [30:0] frc_lim;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    vec32_t      tgt;
    logic [30:0] radius;
  } cfg_t;

  typedef struct packed {
    logic        zero;
    logic [30:0] frc_lim;
    vec32_t      vel;
  } side_t;

  typedef struct packed {
    logic        valid;
    scl_op_t     op;
    vec33_t      v;
    logic [30:0] lim;
    logic [30:0] den;
    side_t       side;
  } scl_in_t;

  typedef struct packed {
    logic   valid;
    vec33_t r;
    side_t  side;
  } scl_out_t;

endpackage

[hw/rtl/ssfa_front.sv]
module ssfa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ssfa_pkg::item_t   item_i,
  input  ssfa_pkg::cfg_t    cfg_i,
  output ssfa_pkg::scl_in_t out_o
);
  import ssfa_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    vec33_t      d;
    vec32_t      vel;
    logic [30:0] speed;
    logic [30:0] frc_lim;
    logic [30:0] radius;
  } f1_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        mode;
    vec33_t            v;
    logic [2:0][63:0]  sq;
    logic [61:0]       r2;
    vec32_t            vel;
    logic [30:0]       speed;
    logic [30:0]       frc_lim;
    logic [30:0]       radius;
  } f2_t;

  f1_t     f1_r, f1_nxt;
  f2_t     f2_r, f2_nxt;
  scl_in_t out_r, out_nxt;

  // offset to target
  always_comb begin
    f1_nxt.valid   = item_i.valid;
    f1_nxt.mode    = cfg_i.mode;
    f1_nxt.vel     = item_i.vel;
    f1_nxt.speed   = item_i.speed;
    f1_nxt.frc_lim = item_i.frc_lim;
    f1_nxt.radius  = cfg_i.radius;
    for (int i = 0; i < 3; i++) begin
      f1_nxt.d[i] = $signed({cfg_i.tgt[i][31], cfg_i.tgt[i]})
                  - $signed({item_i.pos[i][31], item_i.pos[i]});
    end
  end

  // squares of the offset, flee direction
  always_comb begin
    logic [32:0] a;
    a = '0;
    f2_nxt.valid   = f1_r.valid;
    f2_nxt.mode    = f1_r.mode;
    f2_nxt.vel     = f1_r.vel;
    f2_nxt.speed   = f1_r.speed;
    f2_nxt.frc_lim = f1_r.frc_lim;
    f2_nxt.radius  = f1_r.radius;
    f2_nxt.r2      = 62'(f1_r.radius) * 62'(f1_r.radius);
    for (int i = 0; i < 3; i++) begin
      a = f1_r.d[i][32] ? 33'(-f1_r.d[i]) : f1_r.d[i];
      f2_nxt.sq[i] = 64'(a[31:0]) * 64'(a[31:0]);
      f2_nxt.v[i] = (f1_r.mode == MODE_FLEE) ? 33'(-f1_r.d[i]) : f1_r.d[i];
    end
  end

  // arrive distance tests
  always_comb begin
    logic [65:0] sum;
    logic        near;
    logic        in_radius;
    logic        arrive;
    sum       = 66'(f2_r.sq[0]) + 66'(f2_r.sq[1]) + 66'(f2_r.sq[2]);
    near      = sum < EPS_SQ;
    in_radius = (sum < 66'(f2_r.r2)) && (f2_r.radius != '0);
    arrive    = f2_r.mode == MODE_ARRIVE;
    out_nxt.valid = f2_r.valid;
    out_nxt.op    = OP_SCALE;
    if (arrive) begin
      out_nxt.op = near ? OP_ZERO : (in_radius ? OP_DIRECT : OP_SCALE);
    end
    out_nxt.v            = f2_r.v;
    out_nxt.lim          = f2_r.speed;
    out_nxt.den          = f2_r.radius;
    out_nxt.side.zero    = arrive && near;
    out_nxt.side.frc_lim = f2_r.frc_lim;
    out_nxt.side.vel     = f2_r.vel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r  <= '0;
      f2_r  <= '0;
      out_r <= '0;
    end else begin
      f1_r  <= f1_nxt;
      f2_r  <= f2_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_o = out_r;

endmodule

[hw/rtl/ssfa_scale.sv]
module ssfa_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  ssfa_pkg::scl_in_t  in_i,
  output ssfa_pkg::scl_out_t out_o
);
  import ssfa_pkg::*;

  typedef struct packed {
    logic             valid;
    scl_op_t          op;
    vec33_t           v;
    logic [2:0]       neg;
    logic [2:0][32:0] m;
    logic [32:0]      big;
    logic [30:0]      lim;
    logic [30:0]      den;
    side_t            side;
  } n1_t;

  typedef struct packed {
    n1_t        b;
    logic [4:0] sl;
    logic [1:0] sr;
  } n2_t;

  typedef struct packed {
    logic             valid;
    scl_op_t          op;
    vec33_t           v;
    logic [2:0]       neg;
    logic [2:0][30:0] ms;
    logic [2:0][30:0] a;
    logic [30:0]      lim;
    logic [30:0]      den;
    side_t            side;
  } n3_t;

  typedef struct packed {
    logic             valid;
    scl_op_t          op;
    vec33_t           v;
    logic [2:0]       neg;
    logic [2:0][61:0] sq;
    logic [2:0][61:0] pr;
    logic [30:0]      den;
    side_t            side;
  } n4_t;

  typedef struct packed {
    logic             valid;
    scl_op_t          op;
    vec33_t           v;
    logic [2:0]       neg;
    logic [63:0]      n;
    logic [63:0]      res;
    logic [2:0][61:0] pr;
    logic [30:0]      den;
    side_t            side;
  } sq_t;

  typedef struct packed {
    logic             valid;
    scl_op_t          op;
    vec33_t           v;
    logic [2:0]       neg;
    logic [31:0]      dvs;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] ql;
    side_t            side;
  } dv_t;

  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [63:0] b;
    logic [63:0] t;
    sq_t         o;
    o = s;
    b = 64'd1 << (62 - 2 * k);
    t = s.res + b;
    if (s.n >= t) begin
      o.n   = s.n - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic dv_t div_step(dv_t s);
    logic [32:0] t;
    logic        ge;
    dv_t         o;
    o = s;
    for (int i = 0; i < 3; i++) begin
      t  = {s.rem[i], s.ql[i][30]};
      ge = t >= {1'b0, s.dvs};
      o.rem[i] = ge ? 32'(t - {1'b0, s.dvs}) : t[31:0];
      o.ql[i]  = {s.ql[i][29:0], ge};
    end
    return o;
  endfunction

  n1_t      n1_r, n1_nxt;
  n2_t      n2_r, n2_nxt;
  n3_t      n3_r, n3_nxt;
  n4_t      n4_r, n4_nxt;
  sq_t      sq0_nxt;
  dv_t      dv0_nxt;
  scl_out_t out_r, out_nxt;
  sq_t      sq_r [0:SQRT_STEPS];
  dv_t      dv_r [0:DIV_STEPS];

  // magnitudes and largest component
  always_comb begin
    n1_nxt.valid = in_i.valid;
    n1_nxt.v     = in_i.v;
    n1_nxt.lim   = in_i.lim;
    n1_nxt.den   = in_i.den;
    n1_nxt.side  = in_i.side;
    n1_nxt.big   = '0;
    for (int i = 0; i < 3; i++) begin
      n1_nxt.neg[i] = in_i.v[i][32];
      n1_nxt.m[i]   = in_i.v[i][32] ? 33'(-in_i.v[i]) : in_i.v[i];
      if (n1_nxt.m[i] > n1_nxt.big) begin
        n1_nxt.big = n1_nxt.m[i];
      end
    end
    n1_nxt.op = in_i.op;
    if (in_i.op == OP_SCALE && n1_nxt.big == '0) begin
      n1_nxt.op = OP_ZERO;
    end
  end

  // normalize amount: leading one to bit 30
  always_comb begin
    logic [5:0] p;
    p = '0;
    for (int j = 0; j < 33; j++) begin
      if (n1_r.big[j]) begin
        p = 6'(j);
      end
    end
    n2_nxt.b = n1_r;
    if (p > 6'd30) begin
      n2_nxt.sr = 2'(p - 6'd30);
      n2_nxt.sl = '0;
    end else begin
      n2_nxt.sr = '0;
      n2_nxt.sl = 5'(6'd30 - p);
    end
  end

  always_comb begin
    n3_nxt.valid = n2_r.b.valid;
    n3_nxt.op    = n2_r.b.op;
    n3_nxt.v     = n2_r.b.v;
    n3_nxt.neg   = n2_r.b.neg;
    n3_nxt.lim   = n2_r.b.lim;
    n3_nxt.den   = n2_r.b.den;
    n3_nxt.side  = n2_r.b.side;
    for (int i = 0; i < 3; i++) begin
      n3_nxt.ms[i] = 31'((n2_r.b.m[i] >> n2_r.sr) << n2_r.sl);
      n3_nxt.a[i]  = (n2_r.b.op == OP_DIRECT) ? n2_r.b.m[i][30:0] : n3_nxt.ms[i];
    end
  end

  always_comb begin
    n4_nxt.valid = n3_r.valid;
    n4_nxt.op    = n3_r.op;
    n4_nxt.v     = n3_r.v;
    n4_nxt.neg   = n3_r.neg;
    n4_nxt.den   = n3_r.den;
    n4_nxt.side  = n3_r.side;
    for (int i = 0; i < 3; i++) begin
      n4_nxt.sq[i] = 62'(n3_r.ms[i]) * 62'(n3_r.ms[i]);
      n4_nxt.pr[i] = 62'(n3_r.a[i]) * 62'(n3_r.lim);
    end
  end

  always_comb begin
    sq0_nxt.valid = n4_r.valid;
    sq0_nxt.op    = n4_r.op;
    sq0_nxt.v     = n4_r.v;
    sq0_nxt.neg   = n4_r.neg;
    sq0_nxt.n     = 64'(n4_r.sq[0]) + 64'(n4_r.sq[1]) + 64'(n4_r.sq[2]);
    sq0_nxt.res   = '0;
    sq0_nxt.pr    = n4_r.pr;
    sq0_nxt.den   = n4_r.den;
    sq0_nxt.side  = n4_r.side;
  end

  // divisor is the length, or the slowing radius
  always_comb begin
    dv0_nxt.valid = sq_r[SQRT_STEPS].valid;
    dv0_nxt.op    = sq_r[SQRT_STEPS].op;
    dv0_nxt.v     = sq_r[SQRT_STEPS].v;
    dv0_nxt.neg   = sq_r[SQRT_STEPS].neg;
    dv0_nxt.side  = sq_r[SQRT_STEPS].side;
    dv0_nxt.dvs   = (sq_r[SQRT_STEPS].op == OP_DIRECT) ? {1'b0, sq_r[SQRT_STEPS].den}
                                                       : sq_r[SQRT_STEPS].res[31:0];
    for (int i = 0; i < 3; i++) begin
      dv0_nxt.rem[i] = {1'b0, sq_r[SQRT_STEPS].pr[i][61:31]};
      dv0_nxt.ql[i]  = sq_r[SQRT_STEPS].pr[i][30:0];
    end
  end

  always_comb begin
    logic [32:0] q;
    q = '0;
    out_nxt.valid = dv_r[DIV_STEPS].valid;
    out_nxt.side  = dv_r[DIV_STEPS].side;
    for (int i = 0; i < 3; i++) begin
      q = {2'b00, dv_r[DIV_STEPS].ql[i]};
      case (dv_r[DIV_STEPS].op)
        OP_PASS: out_nxt.r[i] = dv_r[DIV_STEPS].v[i];
        OP_ZERO: out_nxt.r[i] = '0;
        default: out_nxt.r[i] = dv_r[DIV_STEPS].neg[i] ? 33'(-q) : q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_r    <= '0;
      n2_r    <= '0;
      n3_r    <= '0;
      n4_r    <= '0;
      sq_r[0] <= '0;
      dv_r[0] <= '0;
      out_r   <= '0;
    end else begin
      n1_r    <= n1_nxt;
      n2_r    <= n2_nxt;
      n3_r    <= n3_nxt;
      n4_r    <= n4_nxt;
      sq_r[0] <= sq0_nxt;
      dv_r[0] <= dv0_nxt;
      out_r   <= out_nxt;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1] <= '0;
      end else begin
        sq_r[k+1] <= sqrt_step(sq_r[k], k);
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= '0;
      end else begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
    end
  end

  assign out_o = out_r;

endmodule

[hw/rtl/steering_seek_flee_arrive_unit.sv]
// throughput: one transaction per cycle, busy stays low; set by the two 70-stage
// rescale pipelines (32 square root stages and 31 divide stages each)
// synchronous active-low reset empties the pipeline and loads mode seek,
// target zero and slowing radius 1.0; the receiver cannot stall results
module steering_seek_flee_arrive_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [30:0]        in_speed_limit,
  input  logic [30:0]        in_force_limit,
  output logic               out_valid,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ssfa_pkg::*;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [30:0] frc_lim;
    vec33_t      steer;
  } m1_t;

  typedef struct packed {
    m1_t              b;
    logic [2:0][65:0] sq;
    logic [61:0]      f2;
  } m2_t;

  typedef struct packed {
    logic        valid;
    vec32_t      f;
  } res_t;

  cfg_t     cfg_r;
  item_t    item;
  scl_in_t  s1_in;
  scl_out_t s1_out;
  scl_in_t  s2_in_r, s2_in_nxt;
  scl_out_t s2_out;
  m1_t      m1_r, m1_nxt;
  m2_t      m2_r, m2_nxt;
  res_t     out_r, out_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_SEEK;
      cfg_r.tgt    <= '0;
      cfg_r.radius <= 31'(1 << FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:     cfg_r.mode   <= cfg_data[1:0];
        REG_TARGET_X: cfg_r.tgt[0] <= cfg_data;
        REG_TARGET_Y: cfg_r.tgt[1] <= cfg_data;
        REG_TARGET_Z: cfg_r.tgt[2] <= cfg_data;
        REG_RADIUS:   cfg_r.radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.valid   = start && !busy;
    item.pos     = {in_pos_z, in_pos_y, in_pos_x};
    item.vel     = {in_vel_z, in_vel_y, in_vel_x};
    item.speed   = in_speed_limit;
    item.frc_lim = in_force_limit;
  end

  ssfa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (item),
    .cfg_i  (cfg_r),
    .out_o  (s1_in)
  );

  ssfa_scale u_desired (
    .clk   (clk),
    .rst_n (rst_n),
    .in_i  (s1_in),
    .out_o (s1_out)
  );

  // steering = desired - velocity
  always_comb begin
    m1_nxt.valid   = s1_out.valid;
    m1_nxt.zero    = s1_out.side.zero;
    m1_nxt.frc_lim = s1_out.side.frc_lim;
    for (int i = 0; i < 3; i++) begin
      m1_nxt.steer[i] = $signed(s1_out.r[i])
                      - $signed({s1_out.side.vel[i][31], s1_out.side.vel[i]});
    end
  end

  always_comb begin
    logic [32:0] a;
    a = '0;
    m2_nxt.b  = m1_r;
    m2_nxt.f2 = 62'(m1_r.frc_lim) * 62'(m1_r.frc_lim);
    for (int i = 0; i < 3; i++) begin
      a = m1_r.steer[i][32] ? 33'(-m1_r.steer[i]) : m1_r.steer[i];
      m2_nxt.sq[i] = 66'(a) * 66'(a);
    end
  end

  // force clamp test
  always_comb begin
    logic [67:0] sum;
    sum = 68'(m2_r.sq[0]) + 68'(m2_r.sq[1]) + 68'(m2_r.sq[2]);
    s2_in_nxt.valid = m2_r.b.valid;
    if (m2_r.b.zero) begin
      s2_in_nxt.op = OP_ZERO;
    end else if (sum > 68'(m2_r.f2)) begin
      s2_in_nxt.op = OP_SCALE;
    end else begin
      s2_in_nxt.op = OP_PASS;
    end
    s2_in_nxt.v    = m2_r.b.steer;
    s2_in_nxt.lim  = m2_r.b.frc_lim;
    s2_in_nxt.den  = 31'd1;
    s2_in_nxt.side = '0;
  end

  ssfa_scale u_clamp (
    .clk   (clk),
    .rst_n (rst_n),
    .in_i  (s2_in_r),
    .out_o (s2_out)
  );

  // saturate to 32 bits
  always_comb begin
    out_nxt.valid = s2_out.valid;
    for (int i = 0; i < 3; i++) begin
      if (s2_out.r[i][32] != s2_out.r[i][31]) begin
        out_nxt.f[i] = s2_out.r[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        out_nxt.f[i] = s2_out.r[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r    <= '0;
      m2_r    <= '0;
      s2_in_r <= '0;
      out_r   <= '0;
    end else begin
      m1_r    <= m1_nxt;
      m2_r    <= m2_nxt;
      s2_in_r <= s2_in_nxt;
      out_r   <= out_nxt;
    end
  end

  assign out_valid   = out_r.valid;
  assign out_force_x = out_r.f[0];
  assign out_force_y = out_r.f[1];
  assign out_force_z = out_r.f[2];

endmodule
